[sv/sdf_pkg.sv]
`default_nettype none
package sdf_pkg;
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS = 2'd0,
    CFG_DAMPING   = 2'd1,
    CFG_REST      = 2'd2,
    CFG_MIN_DIST  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [30:0] stiffness;
    logic [30:0] damping;
    logic [30:0] rest_length;
    logic [30:0] min_distance;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic stall;
  } pipe_ctl_t;
endpackage
`default_nettype wire

[sv/sdf_if.sv]
`default_nettype none
interface sdf_in_if #(parameter int DW = 32);
  logic valid;
  logic ready;
  logic signed [DW-1:0] pos0_x, pos0_y, pos0_z, pos1_x, pos1_y, pos1_z;
  logic signed [DW-1:0] vel0_x, vel0_y, vel0_z, vel1_x, vel1_y, vel1_z;
  modport source (output valid, pos0_x, pos0_y, pos0_z, pos1_x, pos1_y, pos1_z,
                  vel0_x, vel0_y, vel0_z, vel1_x, vel1_y, vel1_z, input ready);
  modport sink (input valid, pos0_x, pos0_y, pos0_z, pos1_x, pos1_y, pos1_z,
                vel0_x, vel0_y, vel0_z, vel1_x, vel1_y, vel1_z, output ready);
endinterface

interface sdf_out_if #(parameter int DW = 32);
  logic valid;
  logic ready;
  logic signed [DW-1:0] force_x, force_y, force_z, force_scalar, length_rate;
  logic [DW-2:0] length;
  logic too_close;
  modport source (output valid, force_x, force_y, force_z, force_scalar, length,
                  length_rate, too_close, input ready);
  modport sink (input valid, force_x, force_y, force_z, force_scalar, length,
                length_rate, too_close, output ready);
endinterface
`default_nettype wire

[sv/sdf_sqrt.sv]
`default_nettype none
// Pipelined restoring square root, one result bit per stage; the sideband rides along.
module sdf_sqrt #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire logic [2*RW-1:0] in_rad,
  input  wire logic [SW-1:0]   in_side,
  output logic                 out_valid,
  output logic [RW-1:0]        out_root,
  output logic [SW-1:0]        out_side
);
  logic [2*RW-1:0] rem_r [RW+1];
  logic [RW-1:0]   root_r [RW+1];
  logic [SW-1:0]   side_r [RW+1];
  logic            vld_r [RW+1];

  always_comb begin
    rem_r[0]  = in_rad;
    root_r[0] = '0;
    side_r[0] = in_side;
    vld_r[0]  = in_valid;
  end

  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int SH = 2 * (RW - 1 - k);
    logic [2*RW+1:0] trial;
    logic [2*RW-1:0] hi;
    logic [2*RW-1:0] rem_nxt;
    logic [RW-1:0]   root_nxt;
    always_comb begin
      hi = rem_r[k] >> SH;
      trial = {2'b00, hi} - {{RW{1'b0}}, root_r[k], 2'b01};
      if (!trial[2*RW+1]) begin
        rem_nxt = rem_r[k] - ({root_r[k], 2'b01} << SH);
        root_nxt = {root_r[k][RW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_r[k];
        root_nxt = {root_r[k][RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (adv) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[RW];
  assign out_root  = root_r[RW];
  assign out_side  = side_r[RW];
endmodule
`default_nettype wire

[sv/sdf_div.sv]
`default_nettype none
// Pipelined restoring divider: unsigned numerator by divisor, one quotient bit per stage.
module sdf_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);
  logic [NW-1:0] num_r [NW+1];
  logic [DW-1:0] rem_r [NW+1];
  logic [DW-1:0] den_r [NW+1];
  logic [SW-1:0] side_r [NW+1];
  logic          vld_r [NW+1];

  always_comb begin
    num_r[0]  = in_num;
    rem_r[0]  = '0;
    den_r[0]  = in_den;
    side_r[0] = in_side;
    vld_r[0]  = in_valid;
  end

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW:0]   sh;
    logic [DW+1:0] diff;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] num_nxt;
    always_comb begin
      sh = {rem_r[k], num_r[k][NW-1]};
      diff = {1'b0, sh} - {2'b00, den_r[k]};
      if (!diff[DW+1]) begin
        rem_nxt = diff[DW-1:0];
        num_nxt = {num_r[k][NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DW-1:0];
        num_nxt = {num_r[k][NW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (adv) begin
        num_r[k+1]  <= num_nxt;
        rem_r[k+1]  <= rem_nxt;
        den_r[k+1]  <= den_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[NW];
  assign out_quo   = num_r[NW];
  assign out_side  = side_r[NW];
endmodule
`default_nettype wire

[sv/spring_damper_force_unit.sv]
// Spring-damper force unit.
// Input channel in_*: one beat carries the positions and velocities of two
// points in signed fixed point. Output channel out_*: one beat per input beat
// with the force on point 0, the scalar force, the length, its rate of change
// and the too-close flag. Configuration is written through cfg_we, cfg_idx and
// cfg_data while no beat is in flight; indexes above three are ignored.
// The block is one pipeline: a difference stage, a square stage, a sum stage,
// a square root of DW+1 stages, a compare stage, three parallel dividers of
// DW+FB+1 stages, five stages for the dot product, the scalar force and the
// force products, and the output register. A new beat is taken every cycle
// while the output register is not stalled. The whole pipeline advances
// together; when the receiver holds out_ready low with the output register
// full, the pipeline freezes and in_ready falls, so nothing is lost or
// repeated.
// Synchronous reset empties the pipeline and sets stiffness, damping and rest
// length to zero and the minimum distance to one.
`default_nettype none
module spring_damper_force_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sdf_in_if.sink                     in_ch,
  sdf_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_idx,
  input  wire logic [DATA_WIDTH-2:0] cfg_data
);
  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int QW = DW + FB + 1;
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  logic [DW-2:0] stiff_r, damp_r, rest_r, mind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= '0;
      damp_r  <= '0;
      rest_r  <= '0;
      mind_r  <= {{(DW-2){1'b0}}, 1'b1};
    end else if (cfg_we) begin
      case (sdf_pkg::cfg_idx_t'(cfg_idx))
        sdf_pkg::CFG_STIFFNESS: stiff_r <= cfg_data;
        sdf_pkg::CFG_DAMPING:   damp_r  <= cfg_data;
        sdf_pkg::CFG_REST:      rest_r  <= cfg_data;
        sdf_pkg::CFG_MIN_DIST:  mind_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) sat_sub = s[DW] ? SMIN : SMAX;
    else sat_sub = s[DW-1:0];
  endfunction

  logic out_vld_r;
  logic adv;
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: differences.
  logic s1_v_r;
  logic signed [DW-1:0] d_r [3];
  logic signed [DW-1:0] dv_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_ch.valid;
    if (adv) begin
      d_r[0]  <= sat_sub(in_ch.pos1_x, in_ch.pos0_x);
      d_r[1]  <= sat_sub(in_ch.pos1_y, in_ch.pos0_y);
      d_r[2]  <= sat_sub(in_ch.pos1_z, in_ch.pos0_z);
      dv_r[0] <= sat_sub(in_ch.vel1_x, in_ch.vel0_x);
      dv_r[1] <= sat_sub(in_ch.vel1_y, in_ch.vel0_y);
      dv_r[2] <= sat_sub(in_ch.vel1_z, in_ch.vel0_z);
    end
  end

  // Stage 2: squares.
  logic s2_v_r;
  logic [2*DW-1:0] sq_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic signed [DW-1:0] dv2_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i]  <= (2*DW)'($signed(d_r[i]) * $signed(d_r[i]));
        d2_r[i]  <= d_r[i];
        dv2_r[i] <= dv_r[i];
      end
    end
  end

  // Stage 3: sum of squares.
  localparam int RW = DW + 1;
  localparam int SIDE1 = 6 * DW;
  logic s3_v_r;
  logic [2*RW-1:0] ss_r;
  logic [SIDE1-1:0] side3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
    if (adv) begin
      ss_r <= {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
      side3_r <= {d2_r[0], d2_r[1], d2_r[2], dv2_r[0], dv2_r[1], dv2_r[2]};
    end
  end

  logic sq_v;
  logic [RW-1:0] root;
  logic [SIDE1-1:0] side_sq;
  sdf_sqrt #(.RW(RW), .SW(SIDE1)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(s3_v_r), .in_rad(ss_r), .in_side(side3_r),
    .out_valid(sq_v), .out_root(root), .out_side(side_sq)
  );

  // Stage 4: closeness compare and divider operands.
  logic s4_v_r, close4_r;
  logic [RW-1:0] dist4_r;
  logic [SIDE1-1:0] side4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= sq_v;
    if (adv) begin
      close4_r <= root <= {2'b00, mind_r};
      dist4_r  <= root;
      side4_r  <= side_sq;
    end
  end

  localparam int SIDE2 = 3 * DW + 3 + 1 + RW;
  logic [QW-1:0] num [3];
  logic [RW-1:0] den;
  logic [2:0] neg4;
  for (genvar i = 0; i < 3; i++) begin : g_num
    logic signed [DW-1:0] dc;
    logic [DW-1:0] mag;
    assign dc = side4_r[SIDE1-1-i*DW -: DW];
    assign mag = dc[DW-1] ? DW'(-dc) : DW'(dc);
    assign neg4[i] = dc[DW-1];
    assign num[i] = {1'b0, mag, {FB{1'b0}}};
  end
  assign den = close4_r ? {{(RW-1){1'b0}}, 1'b1} : dist4_r;

  logic dv_v [3];
  logic [QW-1:0] quo [3];
  logic [SIDE2-1:0] side_dv [3];
  logic [SIDE2-1:0] side4x;
  assign side4x = {side4_r[3*DW-1:0], neg4, close4_r, dist4_r};
  for (genvar i = 0; i < 3; i++) begin : g_div
    sdf_div #(.NW(QW), .DW(RW), .SW(SIDE2)) u_div (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_valid(s4_v_r), .in_num(num[i]), .in_den(den), .in_side(side4x),
      .out_valid(dv_v[i]), .out_quo(quo[i]), .out_side(side_dv[i])
    );
  end

  // Stage 5: signed unit vector and its products with the velocity difference.
  localparam int UW = FB + 2;
  localparam int PW = UW + DW;
  logic s5_v_r, close5_r;
  logic [RW-1:0] dist5_r;
  logic signed [UW-1:0] u5_r [3];
  logic signed [PW-1:0] p5_r [3];
  logic [2:0] neg_d;
  logic signed [DW-1:0] dvd [3];
  logic signed [UW-1:0] uc [3];
  assign neg_d = side_dv[0][RW+3:RW+1];
  for (genvar i = 0; i < 3; i++) begin : g_u
    logic [UW-1:0] qm;
    assign dvd[i] = side_dv[0][SIDE2-1-i*DW -: DW];
    assign qm = quo[i][UW-1:0];
    assign uc[i] = side_dv[0][RW] ? '0 : (neg_d[i] ? -$signed(qm) : $signed(qm));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= dv_v[0];
    if (adv) begin
      close5_r <= side_dv[0][RW];
      dist5_r  <= side_dv[0][RW-1:0];
      for (int i = 0; i < 3; i++) begin
        u5_r[i] <= uc[i];
        p5_r[i] <= PW'(uc[i] * dvd[i]);
      end
    end
  end

  // Stage 6: rate and length.
  localparam int AW = PW + 2;
  function automatic logic signed [AW-1:0] fshift(input logic signed [AW-1:0] x);
    fshift = x >>> FB;
  endfunction
  logic s6_v_r, close6_r;
  logic signed [DW-1:0] rate6_r;
  logic [DW-2:0] len6_r;
  logic signed [UW-1:0] u6_r [3];
  logic signed [AW-1:0] acc, accs;
  assign acc = AW'(p5_r[0]) + AW'(p5_r[1]) + AW'(p5_r[2]);
  assign accs = fshift(acc);
  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (adv) s6_v_r <= s5_v_r;
    if (adv) begin
      close6_r <= close5_r;
      u6_r <= u5_r;
      if (close5_r) begin
        rate6_r <= '0;
        len6_r  <= '0;
      end else begin
        if (accs > AW'(SMAX)) rate6_r <= SMAX;
        else if (accs < AW'(SMIN)) rate6_r <= SMIN;
        else rate6_r <= accs[DW-1:0];
        len6_r <= (dist5_r[RW-1:DW-1] != '0) ? {(DW-1){1'b1}} : dist5_r[DW-2:0];
      end
    end
  end

  // Stage 7: the two products of the scalar force.
  localparam int MW = 2 * DW + 1;
  logic s7_v_r, close7_r;
  logic signed [MW-1:0] ks_r, cs_r;
  logic signed [DW-1:0] rate7_r;
  logic [DW-2:0] len7_r;
  logic signed [UW-1:0] u7_r [3];
  logic signed [DW:0] stretch;
  assign stretch = $signed({2'b00, len6_r}) - $signed({2'b00, rest_r});
  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (adv) s7_v_r <= s6_v_r;
    if (adv) begin
      close7_r <= close6_r;
      rate7_r  <= rate6_r;
      len7_r   <= len6_r;
      u7_r     <= u6_r;
      ks_r <= MW'($signed({1'b0, stiff_r}) * stretch);
      cs_r <= MW'($signed({1'b0, damp_r}) * rate6_r);
    end
  end

  // Stage 8: scalar force.
  logic s8_v_r, close8_r;
  logic signed [DW-1:0] sc8_r, rate8_r;
  logic [DW-2:0] len8_r;
  logic signed [UW-1:0] u8_r [3];
  logic signed [MW:0] ssum, ssh;
  assign ssum = {ks_r[MW-1], ks_r} + {cs_r[MW-1], cs_r};
  assign ssh = ssum >>> FB;
  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else if (adv) s8_v_r <= s7_v_r;
    if (adv) begin
      close8_r <= close7_r;
      rate8_r  <= rate7_r;
      len8_r   <= len7_r;
      u8_r     <= u7_r;
      if (ssh > (MW+1)'(SMAX)) sc8_r <= SMAX;
      else if (ssh < (MW+1)'(SMIN)) sc8_r <= SMIN;
      else sc8_r <= ssh[DW-1:0];
    end
  end

  // Stage 9: force products.
  logic s9_v_r, close9_r;
  logic signed [DW-1:0] sc9_r, rate9_r;
  logic [DW-2:0] len9_r;
  logic signed [PW-1:0] fp9_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s9_v_r <= 1'b0;
    else if (adv) s9_v_r <= s8_v_r;
    if (adv) begin
      close9_r <= close8_r;
      sc9_r <= sc8_r;
      rate9_r <= rate8_r;
      len9_r <= len8_r;
      for (int i = 0; i < 3; i++) fp9_r[i] <= PW'(u8_r[i] * sc8_r);
    end
  end

  // Output register.
  logic signed [DW-1:0] fx_r, fy_r, fz_r, sco_r, rto_r;
  logic [DW-2:0] leno_r;
  logic clo_r;
  logic signed [DW-1:0] fs [3];
  for (genvar i = 0; i < 3; i++) begin : g_f
    logic signed [PW-1:0] sh;
    assign sh = fp9_r[i] >>> FB;
    assign fs[i] = (sh > PW'(SMAX)) ? SMAX : (sh < PW'(SMIN)) ? SMIN : sh[DW-1:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= s9_v_r;
    if (adv) begin
      fx_r <= fs[0];
      fy_r <= fs[1];
      fz_r <= fs[2];
      sco_r <= sc9_r;
      rto_r <= rate9_r;
      leno_r <= len9_r;
      clo_r <= close9_r;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.force_x = fx_r;
  assign out_ch.force_y = fy_r;
  assign out_ch.force_z = fz_r;
  assign out_ch.force_scalar = sco_r;
  assign out_ch.length = leno_r;
  assign out_ch.length_rate = rto_r;
  assign out_ch.too_close = clo_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(fx_r) && $stable(sco_r))
    else $error("output beat changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty output register");
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && clo_r |-> fx_r == '0 && leno_r == '0 && rto_r == '0)
    else $error("too-close beat carries a force");
endmodule
`default_nettype wire

[sim/tb_spring_damper_force_unit.sv]
`default_nettype none
module tb_spring_damper_force_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [11:0][31:0] spring_in_t;

  typedef struct {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] force_scalar;
    logic [30:0]        length;
    logic signed [31:0] length_rate;
    logic               too_close;
  } force_res_t;

  typedef struct {
    spring_in_t stim;
    bit         typed;
    force_res_t res;
  } table_row_t;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int LATENCY = 92;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  sdf_pkg::cfg_idx_t cfg_idx = sdf_pkg::CFG_STIFFNESS;
  logic [30:0] cfg_data = '0;

  sdf_in_if #(.DW(32)) in_ch ();
  sdf_out_if #(.DW(32)) out_ch ();

  spring_damper_force_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  logic [30:0] k_stiff = 31'd0;
  logic [30:0] k_damp = 31'd0;
  logic [30:0] k_rest = 31'd0;
  logic [30:0] k_min = 31'd1;

  force_res_t force_queue[$];
  int errors = 0;
  bit idling = 1'b1;

  function automatic longint sat32(longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return x;
  endfunction

  function automatic force_res_t spring_predict(spring_in_t s);
    longint d[3];
    longint dv[3];
    longint u[3];
    longint unsigned sq, dist_v, mag, rem, root, bitv, q;
    longint acc, rate, len, scalar;
    force_res_t r;
    bit close;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = sat32(longint'($signed(s[3+i])) - longint'($signed(s[i])));
      dv[i] = sat32(longint'($signed(s[9+i])) - longint'($signed(s[6+i])));
      mag = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
      sq += mag * mag;
    end
    rem = sq;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    dist_v = root;
    close = dist_v <= longint'(k_min);
    rate = 0;
    len = 0;
    acc = 0;
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (!close) begin
      for (int i = 0; i < 3; i++) begin
        mag = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
        q = (mag << 16) / dist_v;
        u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
        acc += u[i] * dv[i];
      end
      rate = sat32(acc >>> 16);
      len = (dist_v > 64'd2147483647) ? SMAX : longint'(dist_v);
    end
    scalar = sat32((longint'(k_stiff) * (len - longint'(k_rest))
                    + longint'(k_damp) * rate) >>> 16);
    r.force_x = close ? 32'sd0 : 32'(sat32((u[0] * scalar) >>> 16));
    r.force_y = close ? 32'sd0 : 32'(sat32((u[1] * scalar) >>> 16));
    r.force_z = close ? 32'sd0 : 32'(sat32((u[2] * scalar) >>> 16));
    r.force_scalar = 32'(scalar);
    r.length = 31'(len);
    r.length_rate = 32'(rate);
    r.too_close = close;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (force_queue.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        force_res_t e;
        e = force_queue.pop_front();
        if (out_ch.force_x !== e.force_x) report("force_x", out_ch.force_x, e.force_x);
        if (out_ch.force_y !== e.force_y) report("force_y", out_ch.force_y, e.force_y);
        if (out_ch.force_z !== e.force_z) report("force_z", out_ch.force_z, e.force_z);
        if (out_ch.force_scalar !== e.force_scalar)
          report("force_scalar", out_ch.force_scalar, e.force_scalar);
        if (out_ch.length !== e.length) report("length", out_ch.length, e.length);
        if (out_ch.length_rate !== e.length_rate)
          report("length_rate", out_ch.length_rate, e.length_rate);
        if (out_ch.too_close !== e.too_close)
          report("too_close", out_ch.too_close, e.too_close);
      end
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = idling ? $urandom_range(0, 16) : 0;
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_beat(spring_in_t s, bit typed, force_res_t typed_res);
    int gap;
    gap = idling ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    {in_ch.vel1_z, in_ch.vel1_y, in_ch.vel1_x, in_ch.vel0_z, in_ch.vel0_y, in_ch.vel0_x,
     in_ch.pos1_z, in_ch.pos1_y, in_ch.pos1_x, in_ch.pos0_z, in_ch.pos0_y, in_ch.pos0_x} = s;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    force_queue.insert(force_queue.size(), typed ? typed_res : spring_predict(s));
    @(negedge clk);
  endtask

  task automatic write_reg(sdf_pkg::cfg_idx_t idx, logic [30:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    case (idx)
      sdf_pkg::CFG_STIFFNESS: k_stiff = val;
      sdf_pkg::CFG_DAMPING:   k_damp = val;
      sdf_pkg::CFG_REST:      k_rest = val;
      default:                k_min = val;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (force_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      2: return 32'($signed($urandom_range(0, 2048)) - 1024);
      default: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic spring_in_t rand_spring();
    spring_in_t s;
    int pm, vm, shape;
    shape = $urandom_range(0, 9);
    pm = (shape == 0) ? 0 : (shape == 1) ? 3 : (shape < 6) ? 1 : 2;
    vm = $urandom_range(0, 3);
    for (int i = 0; i < 6; i++) s[i] = rand_word(pm);
    for (int i = 6; i < 12; i++) s[i] = rand_word(vm);
    if (shape == 9) begin
      for (int i = 0; i < 3; i++) s[3+i] = s[i] + 32'($signed($urandom_range(0, 4)) - 2);
    end
    return s;
  endfunction

  function automatic logic [30:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 31'd0;
      1: return 31'h7fffffff;
      2: return 31'($urandom_range(0, 32'h40000));
      3: return 31'($urandom_range(0, 32'h4000000));
      default: return 31'($urandom());
    endcase
  endfunction

  table_row_t rows[$];

  task automatic add_row(spring_in_t s, bit typed, force_res_t r);
    table_row_t row;
    row.stim = s;
    row.typed = typed;
    row.res = r;
    rows.insert(rows.size(), row);
  endtask

  function automatic spring_in_t mk(logic [31:0] p0x, logic [31:0] p1x, logic [31:0] p0z,
                                    logic [31:0] p1z, logic [31:0] v0, logic [31:0] v1);
    spring_in_t s;
    s = '0;
    s[0] = p0x; s[3] = p1x; s[2] = p0z; s[5] = p1z;
    s[6] = v0; s[7] = v0; s[8] = v0; s[9] = v1; s[10] = v1; s[11] = v1;
    return s;
  endfunction

  function automatic force_res_t res(logic [30:0] len, bit close);
    force_res_t r;
    r = '{default: '0};
    r.length = len;
    r.too_close = close;
    return r;
  endfunction

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    force_res_t none;
    in_ch.valid = 1'b0;
    {in_ch.vel1_z, in_ch.vel1_y, in_ch.vel1_x, in_ch.vel0_z, in_ch.vel0_y, in_ch.vel0_x,
     in_ch.pos1_z, in_ch.pos1_y, in_ch.pos1_x, in_ch.pos0_z, in_ch.pos0_y, in_ch.pos0_x} = '0;
    none = res(31'd0, 1'b0);
    add_row(mk(0, 0, 0, 0, 0, 0), 1'b1, res(31'd0, 1'b1));
    add_row(mk(0, 1, 0, 0, 0, 0), 1'b1, res(31'd0, 1'b1));
    add_row(mk(32'h80000000, 32'h7fffffff, 0, 0, 0, 0), 1'b1, res(31'h7fffffff, 1'b0));
    add_row(mk(0, 0, 32'h7fffffff, 32'h80000000, 0, 0), 1'b1, res(31'h7fffffff, 1'b0));
    add_row(mk(0, 2, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(0, 32'h10000, 0, 0, 32'h80000000, 32'h7fffffff), 1'b0, none);
    add_row(mk(0, 32'h10000, 0, 0, 32'h7fffffff, 32'h80000000), 1'b0, none);
    add_row(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
               32'hffffffff, 32'h7fffffff), 1'b0, none);
    add_row(mk(32'h30000, 32'hfffd0000, 32'h40000, 32'h40000,
               32'h12345, 32'hfedcb), 1'b0, none);
    add_row(mk(32'hffffffff, 32'hfffffffe, 0, 32'h1, 0, 32'h1), 1'b0, none);
    add_row(mk(32'h55555555, 32'haaaaaaaa, 32'hcccccccc, 32'h33333333,
               32'h0f0f0f0f, 32'hf0f0f0f0), 1'b0, none);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_beat(rows[i].stim, rows[i].typed, rows[i].res);
    wait_drained();

    write_reg(sdf_pkg::CFG_STIFFNESS, 31'h10000);
    write_reg(sdf_pkg::CFG_DAMPING, 31'h8000);
    write_reg(sdf_pkg::CFG_REST, 31'h20000);
    write_reg(sdf_pkg::CFG_MIN_DIST, 31'd1);
    foreach (rows[i]) send_beat(rows[i].stim, 1'b0, none);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      idling = (ph % 3) != 2;
      case (ph)
        0: begin
          write_reg(sdf_pkg::CFG_STIFFNESS, 31'h7fffffff);
          write_reg(sdf_pkg::CFG_DAMPING, 31'h7fffffff);
          write_reg(sdf_pkg::CFG_REST, 31'h7fffffff);
          write_reg(sdf_pkg::CFG_MIN_DIST, 31'h7fffffff);
        end
        1: begin
          write_reg(sdf_pkg::CFG_STIFFNESS, 31'd0);
          write_reg(sdf_pkg::CFG_DAMPING, 31'd0);
          write_reg(sdf_pkg::CFG_REST, 31'd0);
          write_reg(sdf_pkg::CFG_MIN_DIST, 31'd0);
        end
        2: begin
          write_reg(sdf_pkg::CFG_STIFFNESS, 31'h7fffffff);
          write_reg(sdf_pkg::CFG_DAMPING, 31'h7fffffff);
          write_reg(sdf_pkg::CFG_REST, 31'd0);
          write_reg(sdf_pkg::CFG_MIN_DIST, 31'd4);
        end
        default: begin
          write_reg(sdf_pkg::CFG_STIFFNESS, rand_coef());
          write_reg(sdf_pkg::CFG_DAMPING, rand_coef());
          write_reg(sdf_pkg::CFG_REST, rand_coef());
          write_reg(sdf_pkg::CFG_MIN_DIST,
                    ($urandom_range(0, 1) != 0) ? 31'($urandom_range(0, 8)) : rand_coef());
        end
      endcase
      repeat (250) send_beat(rand_spring(), 1'b0, none);
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

[spring_damper_force_unit.f]
sv/sdf_pkg.sv
sv/sdf_if.sv
sv/sdf_sqrt.sv
sv/sdf_div.sv
sv/spring_damper_force_unit.sv
sim/tb_spring_damper_force_unit.sv
